// ===== design/sme_pkg.sv =====
// Shared types, constants and helpers of the stack machine execution unit.
// Used by every module of the design; depends on nothing.
package sme_pkg;

   localparam int STACK_DEPTH = 512;
   localparam int WORD_BITS   = 32;
   localparam int FIELD_BITS  = 32;
   localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
   localparam int DEPTH_BITS  = $clog2(STACK_DEPTH + 1);
   localparam int EXT_BITS    = (WORD_BITS > FIELD_BITS) ? WORD_BITS : FIELD_BITS;

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [DEPTH_BITS-1:0] depth_type;
   typedef logic [FIELD_BITS-1:0] field_type;

   typedef enum logic [3:0] {
      ACT_END     = 4'd0,
      ACT_PUSH    = 4'd1,
      ACT_ADD     = 4'd2,
      ACT_SUB     = 4'd3,
      ACT_DUMP    = 4'd4,
      ACT_POP     = 4'd5,
      ACT_GT      = 4'd6,
      ACT_EQ      = 4'd7,
      ACT_LT      = 4'd8,
      ACT_JMP     = 4'd9,
      ACT_RESERVE = 4'd10,
      ACT_LOAD    = 4'd11,
      ACT_NOP     = 4'd12
   } action_type;

   typedef enum logic [1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_UNDERFLOW = 2'd1,
      FAULT_OVERFLOW  = 2'd2,
      FAULT_BAD_SLOT  = 2'd3
   } fault_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_A,
      ST_READ_B,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
   } mem_ctrl_type;

   typedef struct packed {
      word_type sum;
      logic     lt;
      logic     eq;
   } alu_out_type;

   typedef struct packed {
      logic      print_valid;
      field_type print_value;
      logic      branch_taken;
      field_type branch_target;
      logic      halted;
      fault_type fault;
   } rsp_type;

   // sign-extend or truncate a 32-bit operand to a stack word
   function automatic word_type operand_to_word(input field_type op);
      logic signed [EXT_BITS-1:0] ext;
      ext = EXT_BITS'($signed(op));
      return ext[WORD_BITS-1:0];
   endfunction

   // zero-extend or truncate a stack word to a 32-bit result field
   function automatic field_type word_to_field(input word_type w);
      logic [EXT_BITS-1:0] ext;
      ext = EXT_BITS'(w);
      return ext[FIELD_BITS-1:0];
   endfunction

endpackage

// ===== design/sme_stack_ram.sv =====
// Stack memory: one write port and one read port with registered read data.
// Depends on sme_pkg.
module sme_stack_ram (
   input  logic                 clock,
   input  sme_pkg::mem_ctrl_type ctrl,
   output sme_pkg::word_type    rd_data
);
   import sme_pkg::*;

   word_type store_ff [STACK_DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         store_ff[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= store_ff[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sme_alu.sv =====
// Shared add/subtract unit; also yields signed compare flags of lhs - rhs.
// Depends on sme_pkg.
module sme_alu (
   input  sme_pkg::word_type    lhs,
   input  sme_pkg::word_type    rhs,
   input  logic                 sub,
   output sme_pkg::alu_out_type result
);
   import sme_pkg::*;

   logic [WORD_BITS:0] lhs_ext;
   logic [WORD_BITS:0] rhs_ext;
   logic [WORD_BITS:0] total;

   always_comb begin
      lhs_ext = {lhs[WORD_BITS-1], lhs};
      rhs_ext = {rhs[WORD_BITS-1], rhs};
      if (sub) begin
         rhs_ext = ~rhs_ext;
      end
      total = lhs_ext + rhs_ext + (WORD_BITS+1)'(sub);
      result.sum = total[WORD_BITS-1:0];
      // one extra bit keeps the difference exact, so its top bit is the sign
      result.lt  = total[WORD_BITS];
      result.eq  = (total[WORD_BITS-1:0] == '0);
   end

endmodule

// ===== design/sme_sequencer.sv =====
// Sequencer: clears the stack after reset, steps one instruction through
// operand reads, the shared ALU and write-back. Depends on sme_pkg.
module sme_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [3:0]            req_action,
   input  sme_pkg::field_type    req_operand,
   input  logic                  req_consume,
   input  logic                  req_store_pop,
   output sme_pkg::mem_ctrl_type mem_ctrl,
   input  sme_pkg::word_type     rd_data,
   output sme_pkg::word_type     alu_lhs,
   output sme_pkg::word_type     alu_rhs,
   output logic                  alu_sub,
   input  sme_pkg::alu_out_type  alu_result,
   input  logic                  rsp_free,
   output logic                  rsp_load,
   output sme_pkg::rsp_type      rsp_data
);
   import sme_pkg::*;

   state_type  state_ff, state_in;
   action_type action_ff, action_in;
   field_type  operand_ff, operand_in;
   logic       consume_ff, consume_in;
   logic       store_ff, store_in;
   depth_type  depth_ff, depth_in;
   logic       halt_ff, halt_in;
   word_type   a_ff, a_in;
   addr_type   clr_addr_ff, clr_addr_in;

   logic [1:0] need;
   logic       grow;
   logic       uses_slot;
   logic       slot_ok;
   addr_type   slot;
   fault_type  fault;
   depth_type  depth_m1, depth_m2, depth_p1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         depth_ff    <= '0;
         halt_ff     <= 1'b0;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         depth_ff    <= depth_in;
         halt_ff     <= halt_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      operand_ff <= operand_in;
      consume_ff <= consume_in;
      store_ff   <= store_in;
      a_ff       <= a_in;
   end

   // operand requirements and fault check of the held instruction
   always_comb begin
      need      = 2'd0;
      grow      = 1'b0;
      uses_slot = 1'b0;
      case (action_ff)
         ACT_PUSH, ACT_RESERVE: grow = 1'b1;
         ACT_LOAD: begin
            grow      = 1'b1;
            uses_slot = 1'b1;
         end
         ACT_ADD, ACT_SUB: begin
            need = 2'd2;
            grow = !consume_ff;
         end
         ACT_DUMP: need = 2'd1;
         ACT_POP: begin
            need      = 2'd1;
            uses_slot = store_ff;
         end
         ACT_GT, ACT_EQ, ACT_LT: need = 2'd2;
         default: ;
      endcase
      slot_ok = !operand_ff[FIELD_BITS-1] && (operand_ff < FIELD_BITS'(STACK_DEPTH));
      slot    = operand_ff[ADDR_BITS-1:0];
      if (depth_ff < DEPTH_BITS'(need)) begin
         fault = FAULT_UNDERFLOW;
      end else if (grow && (depth_ff >= DEPTH_BITS'(STACK_DEPTH))) begin
         fault = FAULT_OVERFLOW;
      end else if (uses_slot && !slot_ok) begin
         fault = FAULT_BAD_SLOT;
      end else begin
         fault = FAULT_NONE;
      end
      depth_m1 = depth_ff - DEPTH_BITS'(1);
      depth_m2 = depth_ff - DEPTH_BITS'(2);
      depth_p1 = depth_ff + DEPTH_BITS'(1);
   end

   // a = held top (or slot value for load), b = entry below, fresh from memory
   assign alu_lhs = rd_data;
   assign alu_rhs = a_ff;
   assign alu_sub = (action_ff != ACT_ADD);

   always_comb begin
      state_in    = state_ff;
      action_in   = action_ff;
      operand_in  = operand_ff;
      consume_in  = consume_ff;
      store_in    = store_ff;
      depth_in    = depth_ff;
      halt_in     = halt_ff;
      a_in        = a_ff;
      clr_addr_in = clr_addr_ff;
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      rsp_data    = '0;
      mem_ctrl    = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_ctrl.wr_en   = 1'b1;
            mem_ctrl.wr_addr = clr_addr_ff;
            mem_ctrl.wr_data = '0;
            clr_addr_in      = clr_addr_ff + ADDR_BITS'(1);
            if (clr_addr_ff == ADDR_BITS'(STACK_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in  = action_type'(req_action);
               operand_in = req_operand;
               consume_in = req_consume;
               store_in   = req_store_pop;
               state_in   = ST_READ_A;
            end
         end
         ST_READ_A: begin
            mem_ctrl.rd_en   = 1'b1;
            mem_ctrl.rd_addr = (action_ff == ACT_LOAD) ? slot : depth_m1[ADDR_BITS-1:0];
            state_in         = ST_READ_B;
         end
         ST_READ_B: begin
            a_in             = rd_data;
            mem_ctrl.rd_en   = 1'b1;
            mem_ctrl.rd_addr = depth_m2[ADDR_BITS-1:0];
            state_in         = ST_EXEC;
         end
         ST_EXEC: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (!halt_ff) begin
                  rsp_data.fault = fault;
                  if (fault == FAULT_NONE) begin
                     case (action_ff)
                        ACT_END: halt_in = 1'b1;
                        ACT_PUSH, ACT_RESERVE: begin
                           mem_ctrl.wr_en   = 1'b1;
                           mem_ctrl.wr_addr = depth_ff[ADDR_BITS-1:0];
                           mem_ctrl.wr_data = operand_to_word(operand_ff);
                           depth_in         = depth_p1;
                        end
                        ACT_LOAD: begin
                           mem_ctrl.wr_en   = 1'b1;
                           mem_ctrl.wr_addr = depth_ff[ADDR_BITS-1:0];
                           mem_ctrl.wr_data = a_ff;
                           depth_in         = depth_p1;
                        end
                        ACT_ADD, ACT_SUB: begin
                           mem_ctrl.wr_en   = 1'b1;
                           mem_ctrl.wr_data = alu_result.sum;
                           if (consume_ff) begin
                              mem_ctrl.wr_addr = depth_m2[ADDR_BITS-1:0];
                              depth_in         = depth_m1;
                           end else begin
                              mem_ctrl.wr_addr = depth_ff[ADDR_BITS-1:0];
                              depth_in         = depth_p1;
                           end
                        end
                        ACT_DUMP: begin
                           rsp_data.print_valid = 1'b1;
                           rsp_data.print_value = word_to_field(a_ff);
                           if (consume_ff) begin
                              depth_in = depth_m1;
                           end
                        end
                        ACT_POP: begin
                           mem_ctrl.wr_en   = store_ff;
                           mem_ctrl.wr_addr = slot;
                           mem_ctrl.wr_data = a_ff;
                           depth_in         = depth_m1;
                        end
                        ACT_GT, ACT_EQ, ACT_LT: begin
                           depth_in = depth_m1;
                           if (((action_ff == ACT_GT) && !alu_result.lt && !alu_result.eq) ||
                               ((action_ff == ACT_EQ) && alu_result.eq) ||
                               ((action_ff == ACT_LT) && alu_result.lt)) begin
                              rsp_data.branch_taken  = 1'b1;
                              rsp_data.branch_target = operand_ff;
                           end
                        end
                        ACT_JMP: begin
                           rsp_data.branch_taken  = 1'b1;
                           rsp_data.branch_target = operand_ff;
                        end
                        default: ;
                     endcase
                  end
               end
               rsp_data.halted = halt_in;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   property p_depth_in_range;
      @(posedge clock) disable iff (reset) depth_ff <= DEPTH_BITS'(STACK_DEPTH);
   endproperty
   a_depth_in_range: assert property (p_depth_in_range) else $error("stack depth out of range");

   property p_halt_sticky;
      @(posedge clock) disable iff (reset) halt_ff |=> halt_ff;
   endproperty
   a_halt_sticky: assert property (p_halt_sticky) else $error("halt flag dropped");

   property p_fault_keeps_depth;
      @(posedge clock) disable iff (reset)
         rsp_load && (rsp_data.fault != FAULT_NONE) |=> $stable(depth_ff);
   endproperty
   a_fault_keeps_depth: assert property (p_fault_keeps_depth)
      else $error("faulting item changed stack depth");

   property p_write_only_clear_exec;
      @(posedge clock) disable iff (reset)
         mem_ctrl.wr_en |-> (state_ff == ST_CLEAR) || (state_ff == ST_EXEC && rsp_load);
   endproperty
   a_write_only_clear_exec: assert property (p_write_only_clear_exec)
      else $error("stack write outside clear or retire");

endmodule

// ===== design/stack_machine_execute.sv =====
// Top level of the stack machine execution unit: sequencer, shared ALU,
// stack memory and the result register. Depends on sme_pkg and sub-modules.
//
// Usage:
//   Input channel req_*: one decoded instruction per item (action, operand,
//   consume, store_pop). Result channel rsp_*: exactly one result item per
//   instruction, in order, carrying the dump value, the branch decision for
//   the outside fetcher, the halted flag and the fault code.
//
//   Each instruction passes through the sequencer steps accept, read top
//   (or load slot), read the entry below, then execute and write back. The
//   result is loaded into the result register in the execute step, once the
//   register is free, and rsp_valid rises with that load. The single read port
//   of the stack memory and its registered read data make the two operand
//   reads separate steps; req_ready is high only while the sequencer waits for
//   an instruction, so a new one is accepted only after the last has executed.
//
//   Reset: the stack memory is swept to zero, one entry per cycle, over all
//   STACK_DEPTH (512) entries after reset drops; req_ready stays low during
//   the sweep. Depth and halt flag clear at once.
//
//   Stall: a finished result sits in the result register until rsp_ready;
//   the next instruction is still accepted and read, and holds in the
//   execute step until the register frees up.
module stack_machine_execute (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [3:0]          req_action,
   input  logic signed [31:0]  req_operand,
   input  logic                req_consume,
   input  logic                req_store_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_print_valid,
   output logic signed [31:0]  rsp_print_value,
   output logic                rsp_branch_taken,
   output logic signed [31:0]  rsp_branch_target,
   output logic                rsp_halted,
   output logic [1:0]          rsp_fault
);
   import sme_pkg::*;

   mem_ctrl_type mem_ctrl;
   word_type     rd_data;
   word_type     alu_lhs;
   word_type     alu_rhs;
   logic         alu_sub;
   alu_out_type  alu_result;
   logic         rsp_free;
   logic         rsp_load;
   rsp_type      rsp_next;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   sme_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_operand   (field_type'(req_operand)),
      .req_consume   (req_consume),
      .req_store_pop (req_store_pop),
      .mem_ctrl      (mem_ctrl),
      .rd_data       (rd_data),
      .alu_lhs       (alu_lhs),
      .alu_rhs       (alu_rhs),
      .alu_sub       (alu_sub),
      .alu_result    (alu_result),
      .rsp_free      (rsp_free),
      .rsp_load      (rsp_load),
      .rsp_data      (rsp_next)
   );

   sme_alu u_alu (
      .lhs    (alu_lhs),
      .rhs    (alu_rhs),
      .sub    (alu_sub),
      .result (alu_result)
   );

   sme_stack_ram u_stack_ram (
      .clock   (clock),
      .ctrl    (mem_ctrl),
      .rd_data (rd_data)
   );

   // result register frees up in the same cycle the receiver takes its item
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_print_valid   = rsp_data_ff.print_valid;
   assign rsp_print_value   = $signed(rsp_data_ff.print_value);
   assign rsp_branch_taken  = rsp_data_ff.branch_taken;
   assign rsp_branch_target = $signed(rsp_data_ff.branch_target);
   assign rsp_halted        = rsp_data_ff.halted;
   assign rsp_fault         = rsp_data_ff.fault;

endmodule
